>>> design/bbc_pkg.sv
// Package for the bracket balance checker.
// Stack sizing, bracket character codes, kind and error codes, the inter-module
// structs and the bracket decode functions. No dependencies.
package bbc_pkg;

	// Stack sizing
	localparam int STACK_DEPTH = 64;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH + 1) : 1;

	// Bracket characters (ASCII)
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [1:0] {
		KIND_PAREN = 2'd0,
		KIND_BRACK = 2'd1,
		KIND_BRACE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_UNMATCHED  = 3'd1,
		ERR_WRONG_PAIR = 3'd2,
		ERR_UNCLOSED   = 3'd3,
		ERR_OVERFLOW   = 3'd4
	} err_t;

	// Control -> stack: what to do with the stack this cycle
	typedef struct packed {
		logic          push;
		logic          pop;
		kind_t         kind;
		logic [DW-1:0] depth;
		logic [DW-1:0] next_depth;
	} stack_op_t;

	// Control -> output register: verdict of a string
	typedef struct packed {
		logic load;
		logic balanced;
		err_t error_kind;
	} result_t;

	function automatic kind_t open_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_LPAREN: k = KIND_PAREN;
			CH_LBRACK: k = KIND_BRACK;
			CH_LBRACE: k = KIND_BRACE;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t close_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_RPAREN: k = KIND_PAREN;
			CH_RBRACK: k = KIND_BRACK;
			CH_RBRACE: k = KIND_BRACE;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

>>> design/bracket_balance_checker.sv
// Bracket balance checker top level.
// Depends on bbc_pkg, bbc_stack, bbc_ctrl and bbc_out.
//
// Input channel (in_valid / in_stall): one character byte ch per transaction,
// with last marking the final character of a string. Brackets ( [ { are
// pushed onto a 64-entry kind stack, ) ] } pop it when they match the top;
// every other byte is ignored. The first error in a string is kept.
// Output channel (out_valid / out_stall): one verdict per string, given for
// the transaction with last set: balanced, and error_kind (none, unmatched
// close, wrong pair, unclosed open, stack overflow).
// Throughput: one character per cycle while in_stall is low. The stack top sits
// in a register and the RAM read port prefetches the entry below it every cycle,
// so pops and pushes can follow each other with no gap.
// Latency: the verdict is valid the cycle after the last character is taken.
// Stall: a verdict waiting under out_stall holds in_stall high; otherwise
// input is never stalled.
// Reset: arst_n clears depth, error and output valid at once; stack RAM
// contents need no clearing.
module bracket_balance_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       balanced,
	output logic [2:0] error_kind
);

	bbc_pkg::stack_op_t op;
	bbc_pkg::result_t   res;
	bbc_pkg::kind_t     top;
	bbc_pkg::kind_t     below;
	logic               hold;
	logic               fire;

	assign in_stall = hold;
	assign fire     = in_valid && !hold;

	bbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (ch),
		.last   (last),
		.top    (top),
		.op     (op),
		.res    (res)
	);

	bbc_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.top    (top),
		.below  (below)
	);

	bbc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.out_stall  (out_stall),
		.hold       (hold),
		.out_valid  (out_valid),
		.balanced   (balanced),
		.error_kind (error_kind)
	);

	// A pop takes the prefetched entry as the new top
	a_pop_top: assert property (@(posedge clk) disable iff (!arst_n)
		(op.pop && op.depth > bbc_pkg::DW'(1)) |=> (top == $past(below)))
		else $error("pop did not load the entry below");

endmodule

>>> design/bbc_stack.sv
// Kind stack: synchronous RAM holding pushed kinds, plus a top-of-stack register.
// Depends on bbc_pkg. The RAM is read every cycle at the entry below the next top.
module bbc_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  bbc_pkg::stack_op_t op,
	output bbc_pkg::kind_t    top,
	output bbc_pkg::kind_t    below
);

	bbc_pkg::kind_t mem [bbc_pkg::STACK_DEPTH];
	bbc_pkg::kind_t rd_q;
	bbc_pkg::kind_t top_q;
	logic [bbc_pkg::DW-1:0] rd_ptr;
	logic [bbc_pkg::AW-1:0] rd_addr;
	logic                   primed_q;

	// Entry under the top after this cycle; a push writes one above it, so no overlap
	assign rd_ptr  = op.next_depth - bbc_pkg::DW'(2);
	assign rd_addr = rd_ptr[bbc_pkg::AW-1:0];

	// RAM: one write port (push), one registered read port
	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[op.depth[bbc_pkg::AW-1:0]] <= op.kind;
		end
		rd_q <= mem[rd_addr];
	end

	// Top of stack: new kind on push, entry below on pop
	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q <= op.kind;
		end else if (op.pop) begin
			top_q <= rd_q;
		end
	end

	// Marks that the read port has produced data since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else begin
			primed_q <= 1'b1;
		end
	end

	assign top   = top_q;
	assign below = rd_q;

	// A push and a pop never come together
	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.push && op.pop))
		else $error("stack push and pop in the same cycle");

	// A pop with two or more entries needs the read port primed
	a_pop_primed: assert property (@(posedge clk) disable iff (!arst_n)
		(op.pop && op.depth > bbc_pkg::DW'(1)) |-> primed_q)
		else $error("pop before read data is available");

	// A push only lands below the stack limit
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |-> (op.depth < bbc_pkg::DW'(bbc_pkg::STACK_DEPTH)))
		else $error("push onto a full stack");

endmodule

>>> design/bbc_ctrl.sv
// Bracket decode, stack depth and sticky error, and the verdict of a string.
// Depends on bbc_pkg; drives the stack operation and the result load.
module bbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         ch,
	input  logic               last,
	input  bbc_pkg::kind_t     top,
	output bbc_pkg::stack_op_t op,
	output bbc_pkg::result_t   res
);

	logic [bbc_pkg::DW-1:0] depth_q;
	logic [bbc_pkg::DW-1:0] depth_d;
	bbc_pkg::err_t          sticky_q;
	bbc_pkg::err_t          err_d;
	bbc_pkg::err_t          verdict;
	bbc_pkg::kind_t         ok;
	bbc_pkg::kind_t         ck;
	logic                   push;
	logic                   pop;

	assign ok = bbc_pkg::open_kind(ch);
	assign ck = bbc_pkg::close_kind(ch);

	// Step of one character: push, pop or first error
	always_comb begin
		push  = 1'b0;
		pop   = 1'b0;
		err_d = sticky_q;
		if (fire && sticky_q == bbc_pkg::ERR_NONE) begin
			if (ok != bbc_pkg::KIND_NONE) begin
				if (depth_q == bbc_pkg::DW'(bbc_pkg::STACK_DEPTH)) begin
					err_d = bbc_pkg::ERR_OVERFLOW;
				end else begin
					push = 1'b1;
				end
			end else if (ck != bbc_pkg::KIND_NONE) begin
				if (depth_q == '0) begin
					err_d = bbc_pkg::ERR_UNMATCHED;
				end else if (top == ck) begin
					pop = 1'b1;
				end else begin
					err_d = bbc_pkg::ERR_WRONG_PAIR;
				end
			end
		end
		depth_d = push ? depth_q + bbc_pkg::DW'(1) :
		          pop  ? depth_q - bbc_pkg::DW'(1) : depth_q;
	end

	// Verdict after this character
	always_comb begin
		verdict = err_d;
		if (err_d == bbc_pkg::ERR_NONE && depth_d != '0) begin
			verdict = bbc_pkg::ERR_UNCLOSED;
		end
	end

	// Depth and sticky error; the last character clears both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			sticky_q <= bbc_pkg::ERR_NONE;
		end else if (fire && last) begin
			depth_q  <= '0;
			sticky_q <= bbc_pkg::ERR_NONE;
		end else begin
			depth_q  <= depth_d;
			sticky_q <= err_d;
		end
	end

	assign op.push       = push;
	assign op.pop        = pop;
	assign op.kind       = ok;
	assign op.depth      = depth_q;
	assign op.next_depth = (fire && last) ? '0 : depth_d;

	assign res.load       = fire && last;
	assign res.balanced   = (verdict == bbc_pkg::ERR_NONE);
	assign res.error_kind = verdict;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= bbc_pkg::DW'(bbc_pkg::STACK_DEPTH))
		else $error("stack depth beyond limit");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last) |=> (depth_q == '0 && sticky_q == bbc_pkg::ERR_NONE))
		else $error("string end did not clear state");

	a_error_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != bbc_pkg::ERR_NONE && !(fire && last)) |=> $stable(depth_q))
		else $error("stack moved after an error");

endmodule

>>> design/bbc_out.sv
// Output register for verdicts, with the input stall it implies.
// Depends on bbc_pkg for the result struct.
module bbc_out (
	input  logic             clk,
	input  logic             arst_n,
	input  bbc_pkg::result_t res,
	input  logic             out_stall,
	output logic             hold,
	output logic             out_valid,
	output logic             balanced,
	output logic [2:0]       error_kind
);

	logic          valid_q;
	logic          balanced_q;
	bbc_pkg::err_t error_kind_q;

	// Valid: set on load, cleared when the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (res.load) begin
			balanced_q   <= res.balanced;
			error_kind_q <= res.error_kind;
		end
	end

	// A waiting verdict that is stalled holds off new characters
	assign hold       = valid_q && out_stall;
	assign out_valid  = valid_q;
	assign balanced   = balanced_q;
	assign error_kind = error_kind_q;

endmodule

>>> verif/bracket_balance_checker_tb.sv
// Self-checking testbench for bracket_balance_checker: directed and random strings,
// verdicts predicted in-bench and compared per field, random idling and backpressure.
// Depends on bbc_pkg (stack depth, bracket characters, kind and error enums).
module bracket_balance_checker_tb;
	import bbc_pkg::*;

	typedef struct {
		logic [7:0] c;
		logic       fin;
	} char_item_t;

	typedef struct {
		logic bal;
		err_t code;
	} verdict_t;

	typedef struct packed {
		logic  opens;
		logic  closes;
		kind_t kind;
	} bracket_t;

	// DUT connections, all inputs known from time zero
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] ch = 8'h00;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       balanced;
	logic [2:0] error_kind;

	// Stimulus and expectations
	char_item_t char_queue[$];
	logic [7:0] draft[$];
	verdict_t   verdict_queue[$];

	// Predicted checker state
	kind_t nest[STACK_DEPTH];
	int    nest_depth = 0;
	err_t  sticky = ERR_NONE;

	// Bookkeeping
	int   total_chars = 0;
	int   chars_sent = 0;
	int   strings_sent = 0;
	int   code_seen[8];
	int   fail_count = 0;
	int   verdicts_done = 0;
	int   in_held_cycles = 0;
	int   send_gap = 0;
	int   rx_gap = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	logic calm = 1'b0;
	char_item_t nxt;
	verdict_t   want;

	bracket_balance_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.balanced  (balanced),
		.error_kind(error_kind)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decode a byte into opener / closer and bracket kind
	function automatic bracket_t classify(input logic [7:0] c);
		bracket_t b;
		b = '{opens: 1'b0, closes: 1'b0, kind: KIND_NONE};
		case (c)
			CH_LPAREN: begin b.opens = 1'b1; b.kind = KIND_PAREN; end
			CH_LBRACK: begin b.opens = 1'b1; b.kind = KIND_BRACK; end
			CH_LBRACE: begin b.opens = 1'b1; b.kind = KIND_BRACE; end
			CH_RPAREN: begin b.closes = 1'b1; b.kind = KIND_PAREN; end
			CH_RBRACK: begin b.closes = 1'b1; b.kind = KIND_BRACK; end
			CH_RBRACE: begin b.closes = 1'b1; b.kind = KIND_BRACE; end
			default: ;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] bracket_char(input kind_t k, input logic closing);
		logic [7:0] c;
		case (k)
			KIND_PAREN: c = closing ? CH_RPAREN : CH_LPAREN;
			KIND_BRACK: c = closing ? CH_RBRACK : CH_LBRACK;
			default:    c = closing ? CH_RBRACE : CH_LBRACE;
		endcase
		return c;
	endfunction

	// Any byte that is not one of the six brackets
	function automatic logic [7:0] filler_byte();
		logic [7:0] c;
		bracket_t   b;
		do begin
			c = 8'($urandom_range(0, 255));
			b = classify(c);
		end while (b.kind != KIND_NONE);
		return c;
	endfunction

	function automatic kind_t random_kind();
		return kind_t'($urandom_range(0, 2));
	endfunction

	// Predict the effect of one accepted character; queue a verdict on the last one
	task automatic judge_char(input logic [7:0] c, input logic is_last);
		bracket_t b;
		verdict_t v;
		b = classify(c);
		if (sticky == ERR_NONE) begin
			if (b.opens) begin
				if (nest_depth >= STACK_DEPTH) begin
					sticky = ERR_OVERFLOW;
				end else begin
					nest[nest_depth] = b.kind;
					nest_depth++;
				end
			end else if (b.closes) begin
				if (nest_depth == 0)
					sticky = ERR_UNMATCHED;
				else if (nest[nest_depth-1] == b.kind)
					nest_depth--;
				else
					sticky = ERR_WRONG_PAIR;
			end
		end
		if (is_last) begin
			v.code = sticky;
			if (v.code == ERR_NONE && nest_depth != 0)
				v.code = ERR_UNCLOSED;
			v.bal = (v.code == ERR_NONE);
			verdict_queue.push_back(v);
			code_seen[v.code]++;
			nest_depth = 0;
			sticky = ERR_NONE;
		end
	endtask

	// Move the draft string into the send queue, flagging its final byte
	task automatic commit_draft();
		char_item_t it;
		for (int i = 0; i < draft.size(); i++) begin
			it.c = draft[i];
			it.fin = (i == draft.size() - 1);
			char_queue.push_back(it);
		end
		draft.delete();
		strings_sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
		commit_draft();
	endtask

	// d openers of random kind, then the matching closers
	task automatic add_deep(input int d);
		kind_t ks[$];
		kind_t k;
		for (int i = 0; i < d; i++) begin
			k = random_kind();
			ks.push_back(k);
			draft.push_back(bracket_char(k, 1'b0));
		end
		while (ks.size() > 0)
			draft.push_back(bracket_char(ks.pop_back(), 1'b1));
		commit_draft();
	endtask

	// Well-nested string with filler, then sometimes broken on purpose
	task automatic add_nested(input int len, input int max_open);
		kind_t ks[$];
		kind_t k;
		int    pick;
		int    pos;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4 && ks.size() < max_open) begin
				k = random_kind();
				ks.push_back(k);
				draft.push_back(bracket_char(k, 1'b0));
			end else if (pick < 7 && ks.size() > 0) begin
				draft.push_back(bracket_char(ks.pop_back(), 1'b1));
			end else begin
				draft.push_back(filler_byte());
			end
		end
		while (ks.size() > 0)
			draft.push_back(bracket_char(ks.pop_back(), 1'b1));
		if (draft.size() == 0)
			draft.push_back(filler_byte());
		pick = $urandom_range(0, 9);
		pos = $urandom_range(0, draft.size() - 1);
		if (pick == 6) begin
			// swap in a random bracket
			draft[pos] = bracket_char(random_kind(), 1'($urandom_range(0, 1)));
		end else if (pick == 7) begin
			// drop one byte, often leaving an opener unclosed
			draft.delete(pos);
		end else if (pick == 8) begin
			// stray closer
			draft.insert(pos, bracket_char(random_kind(), 1'b1));
		end else if (pick == 9) begin
			// raw noise bytes
			draft.delete();
			repeat ($urandom_range(1, 12))
				draft.push_back(8'($urandom_range(0, 255)));
		end
		if (draft.size() == 0)
			draft.push_back(filler_byte());
		commit_draft();
	endtask

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	// Driver: predicts each accepted transaction and offers the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				judge_char(ch, last);
				chars_sent++;
			end
			if (in_valid && in_stall)
				in_held_cycles++;
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (char_queue.size() > 0) begin
					nxt = char_queue.pop_front();
					in_valid <= 1'b1;
					ch <= nxt.c;
					last <= nxt.fin;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
			calm <= (char_queue.size() < 120);
		end
	end

	// Long receiver hold-off once, to fill the block and stall its input
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && verdicts_done >= 30) begin
				hold_left <= 150;
				hold_done <= 1'b1;
			end
		end
	end

	// Monitor: check each verdict transaction, drive out_stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				verdicts_done <= verdicts_done + 1;
				if (verdict_queue.size() == 0) begin
					note_failure($sformatf("unexpected verdict balanced=%0b error_kind=%0d",
						balanced, error_kind));
				end else begin
					want = verdict_queue.pop_front();
					if (balanced !== want.bal || error_kind !== want.code)
						note_failure($sformatf(
							"verdict %0d: expected balanced=%0b error_kind=%0d (%s), got %0b/%0d",
							verdicts_done, want.bal, want.code, want.code.name(),
							balanced, error_kind));
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(1, 9) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus, reset, end of run
	initial begin
		int pick;
		// directed: field extremes, every bracket, each error path
		draft.push_back(8'h00);
		commit_draft();
		draft.push_back(8'hFF);
		commit_draft();
		add_text("x");
		add_text("([{}])");
		add_text(")");
		add_text("(]");
		add_text("{");
		add_text(")((");
		add_text("(a)");
		add_text("}");
		// full stack exactly, then one past it
		add_deep(STACK_DEPTH);
		add_deep(STACK_DEPTH + 1);
		// random strings, mostly well-formed, some deep
		while (char_queue.size() < 800) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				add_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2));
			else if (pick < 4)
				add_nested($urandom_range(16, 48), $urandom_range(8, 24));
			else
				add_nested($urandom_range(1, 16), $urandom_range(1, 8));
		end
		total_chars = char_queue.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (chars_sent < total_chars)
			@(negedge clk);
		while (verdict_queue.size() > 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Checked %0d strings (%0d characters): %0d balanced, %0d unmatched close,",
			strings_sent, total_chars, code_seen[ERR_NONE], code_seen[ERR_UNMATCHED]);
		$display("%0d wrong pair, %0d unclosed, %0d overflow; input stalled %0d cycles",
			code_seen[ERR_WRONG_PAIR], code_seen[ERR_UNCLOSED], code_seen[ERR_OVERFLOW],
			in_held_cycles);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2400000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
design/bbc_pkg.sv
design/bbc_stack.sv
design/bbc_ctrl.sv
design/bbc_out.sv
design/bracket_balance_checker.sv
verif/bracket_balance_checker_tb.sv
